// ===== sv/wrc_pkg.sv =====
package wrc_pkg;

  // FNV-1a 32-bit constants.
  localparam logic [31:0] FnvBasis = 32'h811C_9DC5;
  localparam logic [31:0] FnvPrime = 32'h0100_0193;

  // Record header layout.
  localparam logic [5:0] HashedHdrBytes = 6'd36;
  localparam logic [5:0] LastHdrIdx     = 6'd39;

  // Default depth of the command queue between the parser and the hash engine.
  localparam int unsigned WrcQueueDepth = 2;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_MAGIC  = 1'b0,
    CFG_SCHEMA = 1'b1
  } cfg_idx_e;

  // Record verdict codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_CSUM     = 2'd3
  } status_e;

  // One input request: a byte of the log stream.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } wrc_in_t;

  // Header fields that travel with a verdict.
  typedef struct packed {
    logic [63:0]        sequence_res;
    logic signed [63:0] stamp_ns;
    logic [7:0]         entry_kind;
    logic [31:0]        action_bytes;
    logic [31:0]        payload_bytes;
  } wrc_fields_t;

  // One result request.
  typedef struct packed {
    logic [1:0]         status;
    logic [63:0]        sequence_res;
    logic signed [63:0] stamp_ns;
    logic [7:0]         entry_kind;
    logic [31:0]        action_bytes;
    logic [31:0]        payload_bytes;
  } wrc_out_t;

  // Command from the parser to the hash engine, one per accepted byte outside the discard phase.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        hdr_hash;    // fold the byte into the header hash
    logic        body_hash;   // fold the byte into the body hash
    logic        load_accum;  // header done: seed the accumulator with the header hash
    logic        part_end;    // last byte of a body part: fold its hash into the accumulator
    logic        emit;        // produce a result
    logic        check;       // status comes from the checksum compare
    status_e     status;      // status when no checksum compare is made
    logic        restart;     // return the hash state to its record-start values
    logic [31:0] stored_sum;
    wrc_fields_t fields;
  } wrc_cmd_t;

  // One FNV-1a step over a byte.
  function automatic logic [31:0] fnv_step(logic [31:0] h, logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FnvPrime;
  endfunction

endpackage

// ===== sv/wal_record_checker.sv =====
// Write-ahead-log record checker. Log bytes arrive one per request, starting at
// the first record after the file header, and each record yields one result:
// ok, truncated, magic/schema mismatch, or checksum mismatch (FNV-1a-32 over
// header bytes 0 to 35 XORed with the hashes of the non-empty action and
// payload parts, compared with header bytes 36 to 39). The block sustains one
// byte per cycle while the output is not held: the parser takes a byte every
// cycle, and the hash engine behind the command queue completes one FNV-1a step
// (a constant multiply) per cycle. A record's result enters the result register
// once its final byte has passed the command queue and no earlier result waits
// at the output; while one waits, the queue fills, then holds off further input.
// After a mismatch, bytes are dropped with no result up to the last-byte flag.
// Configuration writes are expected only while no record is in flight.
module wal_record_checker #(
  parameter int unsigned QueueDepth = wrc_pkg::WrcQueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wrc_pkg::wrc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wrc_pkg::wrc_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_index_i,
  input  logic [31:0]       cfg_wdata_i
);
  import wrc_pkg::*;

  logic     push, pop, full, empty;
  wrc_cmd_t push_cmd, pop_cmd;

  // Parser: header capture, phase tracking and header checks.
  wrc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Command queue between parser and hash engine.
  wrc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (empty)
  );

  // Hash engine and result register.
  wrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/wrc_fifo.sv =====
module wrc_fifo #(
  parameter int unsigned Depth = wrc_pkg::WrcQueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wrc_pkg::wrc_cmd_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output wrc_pkg::wrc_cmd_t pop_data_o,
  output logic              empty_o
);
  import wrc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  wrc_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  // Pointer and fill-count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/wrc_front.sv =====
module wrc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wrc_pkg::wrc_in_t  in_data_i,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_index_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              full_i,
  output logic              push_o,
  output wrc_pkg::wrc_cmd_t cmd_o
);
  import wrc_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_ACTION  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_DISCARD = 4'b1000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] byte_idx_q, byte_idx_d;
  logic [31:0] exp_magic_q, exp_schema_q;

  // Captured header words.
  logic [31:0] magic_q, magic_d;
  logic [31:0] schema_q, schema_d;
  logic [63:0] seq_q, seq_d;
  logic [63:0] stamp_q, stamp_d;
  logic [7:0]  kind_q, kind_d;
  logic [31:0] act_len_q, act_len_d;
  logic [31:0] pay_len_q, pay_len_d;
  logic [31:0] sum_q, sum_d;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic [5:0]  hidx;
  logic [5:0]  act_off;
  logic [5:0]  pay_off;
  logic [31:0] cnt_inc;
  logic        mismatch;
  wrc_fields_t fields_new;
  wrc_fields_t fields_reg;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (phase_q != PH_DISCARD);
  assign b          = in_data_i.data_byte;
  assign last       = in_data_i.last_byte;
  assign hidx       = byte_idx_q[5:0];
  assign act_off    = hidx - 6'd25;
  assign pay_off    = hidx - 6'd29;
  assign cnt_inc    = byte_idx_q + 32'd1;

  // Header byte capture; each field byte is set once per record.
  always_comb begin
    magic_d   = magic_q;
    schema_d  = schema_q;
    seq_d     = seq_q;
    stamp_d   = stamp_q;
    kind_d    = kind_q;
    act_len_d = act_len_q;
    pay_len_d = pay_len_q;
    sum_d     = sum_q;
    if (accept && phase_q == PH_HEADER) begin
      case (hidx) inside
        [6'd0:6'd3]:   magic_d[{hidx[1:0], 3'b000} +: 8] = b;
        [6'd4:6'd7]:   schema_d[{hidx[1:0], 3'b000} +: 8] = b;
        [6'd8:6'd15]:  seq_d[{hidx[2:0], 3'b000} +: 8] = b;
        [6'd16:6'd23]: stamp_d[{hidx[2:0], 3'b000} +: 8] = b;
        6'd24:         kind_d = b;
        [6'd25:6'd28]: act_len_d[{act_off[1:0], 3'b000} +: 8] = b;
        [6'd29:6'd32]: pay_len_d[{pay_off[1:0], 3'b000} +: 8] = b;
        [6'd36:6'd39]: sum_d[{hidx[1:0], 3'b000} +: 8] = b;
        default: ;
      endcase
    end
  end

  assign mismatch = (magic_d != exp_magic_q) || (schema_d != exp_schema_q);

  assign fields_new = '{sequence_res: seq_d, stamp_ns: stamp_d, entry_kind: kind_d,
                        action_bytes: act_len_d, payload_bytes: pay_len_d};
  assign fields_reg = '{sequence_res: seq_q, stamp_ns: stamp_q, entry_kind: kind_q,
                        action_bytes: act_len_q, payload_bytes: pay_len_q};

  // Record parser: phase tracking and command build.
  always_comb begin
    phase_d       = phase_q;
    byte_idx_d    = byte_idx_q;
    cmd_o         = '0;
    cmd_o.data_byte = b;
    cmd_o.status  = ST_OK;
    if (accept) begin
      unique case (phase_q)
        PH_HEADER: begin
          cmd_o.hdr_hash = (hidx < HashedHdrBytes);
          if (hidx != LastHdrIdx) begin
            byte_idx_d = cnt_inc;
            if (last) begin
              cmd_o.emit    = 1'b1;
              cmd_o.status  = ST_TRUNC;
              cmd_o.restart = 1'b1;
              byte_idx_d    = '0;
            end
          end else begin
            byte_idx_d       = '0;
            cmd_o.fields     = fields_new;
            cmd_o.stored_sum = sum_d;
            if (mismatch) begin
              cmd_o.emit    = 1'b1;
              cmd_o.status  = ST_MISMATCH;
              cmd_o.restart = 1'b1;
              phase_d       = last ? PH_HEADER : PH_DISCARD;
            end else begin
              cmd_o.load_accum = 1'b1;
              if (act_len_d != '0) begin
                phase_d = PH_ACTION;
              end else if (pay_len_d != '0) begin
                phase_d = PH_PAYLOAD;
              end else begin
                cmd_o.emit    = 1'b1;
                cmd_o.check   = 1'b1;
                cmd_o.restart = 1'b1;
              end
              if (!cmd_o.emit && last) begin
                cmd_o.emit    = 1'b1;
                cmd_o.status  = ST_TRUNC;
                cmd_o.restart = 1'b1;
                phase_d       = PH_HEADER;
              end
            end
          end
        end
        PH_ACTION: begin
          cmd_o.body_hash  = 1'b1;
          cmd_o.fields     = fields_reg;
          cmd_o.stored_sum = sum_q;
          if (cnt_inc >= act_len_q) begin
            cmd_o.part_end = 1'b1;
            byte_idx_d     = '0;
            if (pay_len_q != '0) begin
              phase_d = PH_PAYLOAD;
            end else begin
              cmd_o.emit    = 1'b1;
              cmd_o.check   = 1'b1;
              cmd_o.restart = 1'b1;
              phase_d       = PH_HEADER;
            end
          end else begin
            byte_idx_d = cnt_inc;
          end
          if (!cmd_o.emit && last) begin
            cmd_o.emit    = 1'b1;
            cmd_o.status  = ST_TRUNC;
            cmd_o.restart = 1'b1;
            phase_d       = PH_HEADER;
            byte_idx_d    = '0;
          end
        end
        PH_PAYLOAD: begin
          cmd_o.body_hash  = 1'b1;
          cmd_o.fields     = fields_reg;
          cmd_o.stored_sum = sum_q;
          if (cnt_inc >= pay_len_q) begin
            cmd_o.part_end = 1'b1;
            cmd_o.emit     = 1'b1;
            cmd_o.check    = 1'b1;
            cmd_o.restart  = 1'b1;
            phase_d        = PH_HEADER;
            byte_idx_d     = '0;
          end else begin
            byte_idx_d = cnt_inc;
            if (last) begin
              cmd_o.emit    = 1'b1;
              cmd_o.status  = ST_TRUNC;
              cmd_o.restart = 1'b1;
              phase_d       = PH_HEADER;
              byte_idx_d    = '0;
            end
          end
        end
        PH_DISCARD: begin
          if (last) begin
            phase_d    = PH_HEADER;
            byte_idx_d = '0;
          end
        end
        default: begin
          phase_d    = PH_HEADER;
          byte_idx_d = '0;
        end
      endcase
    end
  end

  // Parser control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      byte_idx_q   <= '0;
      exp_magic_q  <= 32'd0;
      exp_schema_q <= 32'd1;
    end else begin
      phase_q    <= phase_d;
      byte_idx_q <= byte_idx_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MAGIC:  exp_magic_q  <= cfg_wdata_i;
          CFG_SCHEMA: exp_schema_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Header capture registers.
  always_ff @(posedge clk_i) begin
    magic_q   <= magic_d;
    schema_q  <= schema_d;
    seq_q     <= seq_d;
    stamp_q   <= stamp_d;
    kind_q    <= kind_d;
    act_len_q <= act_len_d;
    pay_len_q <= pay_len_d;
    sum_q     <= sum_d;
  end

endmodule

// ===== sv/wrc_back.sv =====
module wrc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  wrc_pkg::wrc_cmd_t cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wrc_pkg::wrc_out_t out_data_o
);
  import wrc_pkg::*;

  logic [31:0] hdr_hash_q, hdr_hash_d;
  logic [31:0] body_hash_q, body_hash_d;
  logic [31:0] accum_q, accum_d;
  logic [31:0] hdr_step, body_step;
  logic        out_valid_q, out_valid_d;
  wrc_out_t    out_q, out_d;
  status_e     verdict;

  assign pop_o       = !empty_i && (!cmd_i.emit || !out_valid_q || out_ready_i);
  assign hdr_step    = fnv_step(hdr_hash_q, cmd_i.data_byte);
  assign body_step   = fnv_step(body_hash_q, cmd_i.data_byte);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Hash engine: one byte step per command.
  always_comb begin
    hdr_hash_d  = hdr_hash_q;
    body_hash_d = body_hash_q;
    accum_d     = accum_q;
    if (pop_o) begin
      if (cmd_i.hdr_hash) begin
        hdr_hash_d = hdr_step;
      end
      if (cmd_i.load_accum) begin
        accum_d = hdr_hash_q;
      end
      if (cmd_i.part_end) begin
        accum_d     = accum_q ^ body_step;
        body_hash_d = FnvBasis;
      end else if (cmd_i.body_hash) begin
        body_hash_d = body_step;
      end
    end
  end

  assign verdict = cmd_i.check ? ((accum_d == cmd_i.stored_sum) ? ST_OK : ST_CSUM)
                               : cmd_i.status;

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (pop_o && cmd_i.emit) begin
      out_valid_d         = 1'b1;
      out_d.status        = verdict;
      out_d.sequence_res  = cmd_i.fields.sequence_res;
      out_d.stamp_ns      = cmd_i.fields.stamp_ns;
      out_d.entry_kind    = cmd_i.fields.entry_kind;
      out_d.action_bytes  = cmd_i.fields.action_bytes;
      out_d.payload_bytes = cmd_i.fields.payload_bytes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_hash_q  <= FnvBasis;
      body_hash_q <= FnvBasis;
      accum_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o && cmd_i.restart) begin
        hdr_hash_q  <= FnvBasis;
        body_hash_q <= FnvBasis;
        accum_q     <= '0;
      end else begin
        hdr_hash_q  <= hdr_hash_d;
        body_hash_q <= body_hash_d;
        accum_q     <= accum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule
